>>> hdl/ps2kg_pkg.sv
// Shared types, constants and lookup tables of the PS/2 keyboard to gamepad decoder.
package ps2kg_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int NUM_WATCH = 31;
    localparam int HELD_SLOTS = 4;

    localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
    localparam logic [7:0] BYTE_EXT    = 8'hE0;
    localparam logic [7:0] BYTE_BREAK  = 8'hF0;

    localparam logic [7:0] MOD_CTRL_MASK = 8'h11;
    localparam logic [7:0] MOD_ALT_MASK  = 8'h44;
    localparam logic [7:0] STICK_CENTER  = 8'd128;
    localparam logic [7:0] STICK_MIN     = 8'd0;
    localparam logic [7:0] STICK_FULL_RESET = 8'd255;

    localparam logic CFG_STICK_FULL = 1'b0;

    typedef logic [8:0] rom_entry_t;
    typedef logic [NUM_WATCH-1:0] watch_hits_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EVAL
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PRESS,
        OP_RELEASE,
        OP_CLEAR
    } slot_op_t;

    typedef struct packed {
        slot_op_t   op;
        logic [7:0] code;
        logic       any_held;
    } slot_cmd_t;

    typedef struct packed {
        logic        match_seen;
        logic        empty_seen;
        watch_hits_t hits;
    } slot_link_t;

    localparam int H_ESC    = 0;
    localparam int H_EQUAL  = 1;
    localparam int H_P      = 2;
    localparam int H_MINUS  = 3;
    localparam int H_J      = 4;
    localparam int H_ENTER  = 5;
    localparam int H_K      = 6;
    localparam int H_BKSP   = 7;
    localparam int H_SEMI   = 8;
    localparam int H_L      = 9;
    localparam int H_U      = 10;
    localparam int H_PGUP   = 11;
    localparam int H_I      = 12;
    localparam int H_PGDN   = 13;
    localparam int H_LBRK   = 14;
    localparam int H_RBRK   = 15;
    localparam int H_V      = 16;
    localparam int H_N      = 17;
    localparam int H_UP     = 18;
    localparam int H_DOWN   = 19;
    localparam int H_LEFT   = 20;
    localparam int H_RIGHT  = 21;
    localparam int H_DEL    = 22;
    localparam int H_A      = 23;
    localparam int H_D      = 24;
    localparam int H_W      = 25;
    localparam int H_S      = 26;
    localparam int H_COMMA  = 27;
    localparam int H_SLASH  = 28;
    localparam int H_M      = 29;
    localparam int H_PERIOD = 30;

    localparam logic [7:0] WATCH_USAGE [NUM_WATCH] = '{
        8'h29, 8'h2E, 8'h13, 8'h2D, 8'h0D, 8'h28, 8'h0E, 8'h2A,
        8'h33, 8'h0F, 8'h18, 8'h4B, 8'h0C, 8'h4E, 8'h2F, 8'h30,
        8'h19, 8'h11, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h4C, 8'h04,
        8'h07, 8'h1A, 8'h16, 8'h36, 8'h38, 8'h10, 8'h37
    };

    function automatic watch_hits_t hits_of(input logic [7:0] usage);
        watch_hits_t h;
        for (int k = 0; k < NUM_WATCH; k++) begin
            h[k] = (usage == WATCH_USAGE[k]);
        end
        return h;
    endfunction

    function automatic rom_entry_t rom_plain(input logic [7:0] b);
        rom_entry_t e;
        case (b)
            8'h01: e = 9'h042;
            8'h03: e = 9'h03E;
            8'h04: e = 9'h03C;
            8'h05: e = 9'h03A;
            8'h06: e = 9'h03B;
            8'h07: e = 9'h045;
            8'h09: e = 9'h043;
            8'h0A: e = 9'h041;
            8'h0B: e = 9'h03F;
            8'h0C: e = 9'h03D;
            8'h0D: e = 9'h02B;
            8'h0E: e = 9'h035;
            8'h11: e = 9'h104;
            8'h12: e = 9'h102;
            8'h14: e = 9'h101;
            8'h15: e = 9'h014;
            8'h16: e = 9'h01E;
            8'h1A: e = 9'h01D;
            8'h1B: e = 9'h016;
            8'h1C: e = 9'h004;
            8'h1D: e = 9'h01A;
            8'h1E: e = 9'h01F;
            8'h21: e = 9'h006;
            8'h22: e = 9'h01B;
            8'h23: e = 9'h007;
            8'h24: e = 9'h008;
            8'h25: e = 9'h021;
            8'h26: e = 9'h020;
            8'h29: e = 9'h02C;
            8'h2A: e = 9'h019;
            8'h2B: e = 9'h009;
            8'h2C: e = 9'h017;
            8'h2D: e = 9'h015;
            8'h2E: e = 9'h022;
            8'h31: e = 9'h011;
            8'h32: e = 9'h005;
            8'h33: e = 9'h00B;
            8'h34: e = 9'h00A;
            8'h35: e = 9'h01C;
            8'h36: e = 9'h023;
            8'h3A: e = 9'h010;
            8'h3B: e = 9'h00D;
            8'h3C: e = 9'h018;
            8'h3D: e = 9'h024;
            8'h3E: e = 9'h025;
            8'h41: e = 9'h036;
            8'h42: e = 9'h00E;
            8'h43: e = 9'h00C;
            8'h44: e = 9'h012;
            8'h45: e = 9'h027;
            8'h46: e = 9'h026;
            8'h49: e = 9'h037;
            8'h4A: e = 9'h038;
            8'h4B: e = 9'h00F;
            8'h4C: e = 9'h033;
            8'h4D: e = 9'h013;
            8'h4E: e = 9'h02D;
            8'h52: e = 9'h034;
            8'h54: e = 9'h02F;
            8'h55: e = 9'h02E;
            8'h58: e = 9'h039;
            8'h59: e = 9'h120;
            8'h5A: e = 9'h028;
            8'h5B: e = 9'h030;
            8'h5D: e = 9'h031;
            8'h66: e = 9'h02A;
            8'h76: e = 9'h029;
            8'h78: e = 9'h044;
            8'h83: e = 9'h040;
            default: e = 9'h000;
        endcase
        return e;
    endfunction

    function automatic rom_entry_t rom_ext(input logic [7:0] b);
        rom_entry_t e;
        case (b)
            8'h11: e = 9'h140;
            8'h14: e = 9'h110;
            8'h1F: e = 9'h108;
            8'h27: e = 9'h180;
            8'h69: e = 9'h04D;
            8'h6B: e = 9'h050;
            8'h6C: e = 9'h04A;
            8'h70: e = 9'h049;
            8'h71: e = 9'h04C;
            8'h72: e = 9'h051;
            8'h74: e = 9'h04F;
            8'h75: e = 9'h052;
            8'h7A: e = 9'h04E;
            8'h7D: e = 9'h04B;
            default: e = 9'h000;
        endcase
        return e;
    endfunction

endpackage

>>> hdl/ps2kg_key_cell.sv
// One key slot of the pressed-key chain, with its match, free-slot and hit links.
module ps2kg_key_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ps2kg_pkg::slot_cmd_t   cmd,
    input  ps2kg_pkg::slot_link_t  link_in,
    output ps2kg_pkg::slot_link_t  link_out,
    output logic [7:0]             slot
);

    logic [7:0] slot_reg;
    logic [7:0] slot_next;
    logic       match;
    logic       empty;

    assign match = (slot_reg == cmd.code);
    assign empty = (slot_reg == 8'd0);

    assign link_out.match_seen = link_in.match_seen | match;
    assign link_out.empty_seen = link_in.empty_seen | empty;
    assign link_out.hits       = link_in.hits | ps2kg_pkg::hits_of(slot_reg);
    assign slot                = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        case (cmd.op)
            ps2kg_pkg::OP_CLEAR: begin
                slot_next = 8'd0;
            end
            ps2kg_pkg::OP_PRESS: begin
                if (!cmd.any_held && !link_in.empty_seen && empty) begin
                    slot_next = cmd.code;
                end
            end
            ps2kg_pkg::OP_RELEASE: begin
                if (match && !link_in.match_seen) begin
                    slot_next = 8'd0;
                end
            end
            default: begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 8'd0;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

>>> hdl/ps2_keyboard_to_gamepad_decoder.sv
// Top level of the PS/2 keyboard to gamepad decoder: frame check, decoder and pad mapping.
//
// The input channel (s_valid, s_ready, s_frame) takes one 11-bit PS/2 frame per beat.
// The frame is checked for start, stop and odd parity, its byte is decoded as scan
// code Set 2, and the key set lives in a row of key slot cells that update together.
// After a good frame with a mapped code or the BAT byte, the gamepad state is built
// and sent on the result channel (m_valid, m_ready, m_*) if it differs from the last
// one sent or none has been sent since reset. Prefix bytes, unmapped codes and bad
// frames give no beat. A mapped code or the BAT byte passes the capture of the frame
// (idle), the decoder and slot chain update (decode), and the build and compare of the
// pad state (eval). A bad frame, a prefix byte or an unmapped code passes capture and
// decode only. s_ready is high only while the block is idle, so a new frame is taken
// only after the last one is through all its steps. A result beat is loaded into the
// output register in the eval step. When the receiver
// stalls, the result is held in the output register; a new result that must be sent
// while the old one still waits holds the block, and s_ready stays low until the old
// beat is taken. Reset (aresetn low, synchronous) empties all key slots, clears the
// modifiers, prefixes and presence flag, sets stick_full to 255 and the last sent
// state to all buttons released with centered sticks.
module ps2_keyboard_to_gamepad_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_buttons,
    output logic [7:0]  m_left_x,
    output logic [7:0]  m_left_y,
    output logic [7:0]  m_right_x,
    output logic [7:0]  m_right_y,
    output logic [31:0] m_held_keys,
    output logic        m_present,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ps2kg_pkg::state_t state_reg;
    ps2kg_pkg::state_t state_next;

    logic [10:0] frame_reg;
    logic [10:0] frame_next;
    logic        ext_reg;
    logic        ext_next;
    logic        brk_reg;
    logic        brk_next;
    logic        seen_reg;
    logic        seen_next;
    logic [7:0]  mod_reg;
    logic [7:0]  mod_next;
    logic [7:0]  stick_full_reg;
    logic [7:0]  stick_full_next;
    logic [16:0] last_buttons_reg;
    logic [16:0] last_buttons_next;
    logic [31:0] last_sticks_reg;
    logic [31:0] last_sticks_next;
    logic        emitted_reg;
    logic        emitted_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [16:0] m_buttons_reg;
    logic [16:0] m_buttons_next;
    logic [31:0] m_sticks_reg;
    logic [31:0] m_sticks_next;
    logic [31:0] m_held_keys_reg;
    logic [31:0] m_held_keys_next;
    logic        m_present_reg;
    logic        m_present_next;

    ps2kg_pkg::slot_cmd_t   cmd;
    ps2kg_pkg::slot_link_t  links [ps2kg_pkg::KEY_SLOTS+1];
    logic [7:0]             slot_val [ps2kg_pkg::KEY_SLOTS];
    ps2kg_pkg::watch_hits_t hits;
    ps2kg_pkg::rom_entry_t  entry;

    logic [7:0]  data;
    logic        frame_ok;
    logic        cfg_write;
    logic        load;
    logic        emit;
    logic [16:0] buttons;
    logic [31:0] sticks;
    logic [31:0] held_keys;

    function automatic logic [7:0] axis(input logic neg, input logic pos,
                                        input logic [7:0] full);
        logic [7:0] v;
        if (neg && !pos) begin
            v = ps2kg_pkg::STICK_MIN;
        end else if (pos && !neg) begin
            v = full;
        end else begin
            v = ps2kg_pkg::STICK_CENTER;
        end
        return v;
    endfunction

    assign links[0] = '0;

    for (genvar i = 0; i < ps2kg_pkg::KEY_SLOTS; i++) begin : g_cell
        ps2kg_key_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .slot     (slot_val[i])
        );
    end

    for (genvar j = 0; j < ps2kg_pkg::HELD_SLOTS; j++) begin : g_held
        if (j < ps2kg_pkg::KEY_SLOTS) begin : g_slot
            assign held_keys[8*j +: 8] = slot_val[j];
        end else begin : g_none
            assign held_keys[8*j +: 8] = 8'd0;
        end
    end

    assign hits     = links[ps2kg_pkg::KEY_SLOTS].hits;
    assign data     = frame_reg[8:1];
    assign frame_ok = !frame_reg[0] && frame_reg[10] && (^frame_reg[9:1]);
    assign entry    = ext_reg ? ps2kg_pkg::rom_ext(data) : ps2kg_pkg::rom_plain(data);

    always_comb begin
        buttons[0]  = hits[ps2kg_pkg::H_ESC] | hits[ps2kg_pkg::H_EQUAL];
        buttons[1]  = hits[ps2kg_pkg::H_P] | hits[ps2kg_pkg::H_MINUS];
        buttons[2]  = hits[ps2kg_pkg::H_J] | hits[ps2kg_pkg::H_ENTER];
        buttons[3]  = hits[ps2kg_pkg::H_K] | hits[ps2kg_pkg::H_BKSP];
        buttons[4]  = hits[ps2kg_pkg::H_SEMI];
        buttons[5]  = hits[ps2kg_pkg::H_L];
        buttons[6]  = hits[ps2kg_pkg::H_U] | hits[ps2kg_pkg::H_PGUP];
        buttons[7]  = hits[ps2kg_pkg::H_I] | hits[ps2kg_pkg::H_PGDN];
        buttons[8]  = hits[ps2kg_pkg::H_LBRK];
        buttons[9]  = hits[ps2kg_pkg::H_RBRK];
        buttons[10] = hits[ps2kg_pkg::H_V];
        buttons[11] = hits[ps2kg_pkg::H_N];
        buttons[12] = hits[ps2kg_pkg::H_UP];
        buttons[13] = hits[ps2kg_pkg::H_DOWN];
        buttons[14] = hits[ps2kg_pkg::H_LEFT];
        buttons[15] = hits[ps2kg_pkg::H_RIGHT];
        buttons[16] = (|(mod_reg & ps2kg_pkg::MOD_CTRL_MASK))
                    && (|(mod_reg & ps2kg_pkg::MOD_ALT_MASK))
                    && hits[ps2kg_pkg::H_DEL];
        sticks[7:0]   = axis(hits[ps2kg_pkg::H_A], hits[ps2kg_pkg::H_D], stick_full_reg);
        sticks[15:8]  = axis(hits[ps2kg_pkg::H_W], hits[ps2kg_pkg::H_S], stick_full_reg);
        sticks[23:16] = axis(hits[ps2kg_pkg::H_COMMA], hits[ps2kg_pkg::H_SLASH],
                             stick_full_reg);
        sticks[31:24] = axis(hits[ps2kg_pkg::H_M], hits[ps2kg_pkg::H_PERIOD],
                             stick_full_reg);
    end

    assign emit = !emitted_reg || (buttons != last_buttons_reg) || (sticks != last_sticks_reg);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        state_next        = state_reg;
        frame_next        = frame_reg;
        ext_next          = ext_reg;
        brk_next          = brk_reg;
        seen_next         = seen_reg;
        mod_next          = mod_reg;
        stick_full_next   = stick_full_reg;
        last_buttons_next = last_buttons_reg;
        last_sticks_next  = last_sticks_reg;
        emitted_next      = emitted_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_buttons_next    = m_buttons_reg;
        m_sticks_next     = m_sticks_reg;
        m_held_keys_next  = m_held_keys_reg;
        m_present_next    = m_present_reg;
        cmd.op            = ps2kg_pkg::OP_NONE;
        cmd.code          = entry[7:0];
        cmd.any_held      = links[ps2kg_pkg::KEY_SLOTS].match_seen;
        load              = 1'b0;

        case (state_reg)
            ps2kg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    frame_next = s_frame;
                    state_next = ps2kg_pkg::ST_DECODE;
                end
            end
            ps2kg_pkg::ST_DECODE: begin
                state_next = ps2kg_pkg::ST_IDLE;
                if (frame_ok) begin
                    if (data == ps2kg_pkg::BYTE_BAT_OK) begin
                        cmd.op     = ps2kg_pkg::OP_CLEAR;
                        mod_next   = 8'd0;
                        ext_next   = 1'b0;
                        brk_next   = 1'b0;
                        seen_next  = 1'b1;
                        state_next = ps2kg_pkg::ST_EVAL;
                    end else if (data == ps2kg_pkg::BYTE_EXT) begin
                        ext_next = 1'b1;
                    end else if (data == ps2kg_pkg::BYTE_BREAK) begin
                        brk_next = 1'b1;
                    end else begin
                        ext_next = 1'b0;
                        brk_next = 1'b0;
                        if (entry != '0) begin
                            state_next = ps2kg_pkg::ST_EVAL;
                            if (entry[8]) begin
                                mod_next = brk_reg ? (mod_reg & ~entry[7:0])
                                                   : (mod_reg | entry[7:0]);
                            end else begin
                                cmd.op = brk_reg ? ps2kg_pkg::OP_RELEASE
                                                 : ps2kg_pkg::OP_PRESS;
                            end
                        end
                    end
                end
            end
            ps2kg_pkg::ST_EVAL: begin
                if (!emit) begin
                    state_next = ps2kg_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    load              = 1'b1;
                    state_next        = ps2kg_pkg::ST_IDLE;
                    last_buttons_next = buttons;
                    last_sticks_next  = sticks;
                    emitted_next      = 1'b1;
                    m_valid_next      = 1'b1;
                    m_buttons_next    = buttons;
                    m_sticks_next     = sticks;
                    m_held_keys_next  = held_keys;
                    m_present_next    = seen_reg;
                end
            end
            default: begin
                state_next = ps2kg_pkg::ST_IDLE;
            end
        endcase

        if (cfg_write && (paddr[2] == ps2kg_pkg::CFG_STICK_FULL)) begin
            stick_full_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ps2kg_pkg::ST_IDLE;
            ext_reg          <= 1'b0;
            brk_reg          <= 1'b0;
            seen_reg         <= 1'b0;
            mod_reg          <= 8'd0;
            stick_full_reg   <= ps2kg_pkg::STICK_FULL_RESET;
            last_buttons_reg <= 17'd0;
            last_sticks_reg  <= {4{ps2kg_pkg::STICK_CENTER}};
            emitted_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ext_reg          <= ext_next;
            brk_reg          <= brk_next;
            seen_reg         <= seen_next;
            mod_reg          <= mod_next;
            stick_full_reg   <= stick_full_next;
            last_buttons_reg <= last_buttons_next;
            last_sticks_reg  <= last_sticks_next;
            emitted_reg      <= emitted_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg       <= frame_next;
        m_buttons_reg   <= m_buttons_next;
        m_sticks_reg    <= m_sticks_next;
        m_held_keys_reg <= m_held_keys_next;
        m_present_reg   <= m_present_next;
    end

    assign s_ready     = (state_reg == ps2kg_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_buttons   = m_buttons_reg;
    assign m_left_x    = m_sticks_reg[7:0];
    assign m_left_y    = m_sticks_reg[15:8];
    assign m_right_x   = m_sticks_reg[23:16];
    assign m_right_y   = m_sticks_reg[31:24];
    assign m_held_keys = m_held_keys_reg;
    assign m_present   = m_present_reg;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == ps2kg_pkg::CFG_STICK_FULL)
                       ? {24'd0, stick_full_reg} : 32'd0;

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ps2kg_pkg::ST_DECODE))
        else $error("Accepted frame did not enter the decode step.");

    a_bad_frame_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ps2kg_pkg::ST_DECODE && !frame_ok)
        |=> (state_reg == ps2kg_pkg::ST_IDLE && $stable(mod_reg) && $stable(seen_reg)
             && $stable(ext_reg) && $stable(brk_reg)))
        else $error("A bad frame changed the decoder state.");

    a_load_tracks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid_reg && m_buttons_reg == last_buttons_reg
                  && m_sticks_reg == last_sticks_reg))
        else $error("Sent pad state differs from the recorded last state.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_ready))
        else $error("A waiting result was overwritten.");

    a_emitted_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(emitted_reg))
        else $error("The sent-once flag cleared without reset.");

endmodule
